// ----- hw/rtl/lkvc_pkg.sv -----
// package for the lru key-value cache: item types, command codes and sizes
// no dependencies; imported by lkvc_store and lru_key_value_cache
package lkvc_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned CAP_W       = 5;
	localparam int unsigned ENTRIES_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

endpackage

// ----- hw/rtl/lkvc_store.sv -----
// entry store of the lru key-value cache: parallel key match, recency ranks,
// eviction and insertion; depends on lkvc_pkg
module lkvc_store #(
	parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  lkvc_pkg::req_t               req,
	input  logic [lkvc_pkg::CAP_W-1:0]   cap,
	output lkvc_pkg::rsp_t               rsp
);
	import lkvc_pkg::*;

	localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
	localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [ENTRIES-1:0]       valid_q;
	logic [RANK_W-1:0]        rank_q [ENTRIES];
	logic [DATA_W-1:0]        key_q [ENTRIES];
	logic [DATA_W-1:0]        value_q [ENTRIES];
	logic [OCC_W-1:0]         occ_q;

	logic [ENTRIES-1:0]       hit_oh;
	logic [ENTRIES-1:0]       oldest_oh;
	logic [ENTRIES-1:0]       valid_after;
	logic [ENTRIES-1:0]       free_oh;
	logic                     found;
	logic [DATA_W-1:0]        hit_value;
	logic [RANK_W-1:0]        hit_rank;
	logic [RANK_W-1:0]        occ_last;
	logic [CMP_W-1:0]         cap_eff;
	logic                     full;
	logic                     is_put;
	logic                     evict;

	always_comb begin
		occ_last  = RANK_W'(occ_q - OCC_W'(1));
		hit_value = '0;
		hit_rank  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_oh[i]    = valid_q[i] && (key_q[i] == req.key);
			oldest_oh[i] = valid_q[i] && (rank_q[i] == occ_last);
			hit_value    = hit_value | (hit_oh[i] ? value_q[i] : '0);
			hit_rank     = hit_rank | (hit_oh[i] ? rank_q[i] : '0);
		end
		found = |hit_oh;
	end

	// zero capacity acts as one; anything above the entry count saturates
	always_comb begin
		cap_eff     = (cap == '0) ? CMP_W'(1) : CMP_W'(cap);
		full        = (CMP_W'(occ_q) >= cap_eff) || (occ_q == OCC_W'(ENTRIES));
		is_put      = (req.command == CMD_PUT);
		evict       = is_put && !found && full;
		valid_after = valid_q & ~(evict ? oldest_oh : '0);
		// lowest free entry after eviction
		free_oh     = ~valid_after & (valid_after + ENTRIES'(1));
	end

	always_comb begin
		rsp.found      = found;
		rsp.read_value = (!is_put && found) ? hit_value : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire) begin
			if (found) begin
				// move the hit entry to the front, younger entries age by one
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit_oh[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end else if (is_put) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (free_oh[i]) begin
						rank_q[i] <= '0;
					end else if (valid_after[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
				valid_q <= valid_after | free_oh;
				if (!evict) begin
					occ_q <= occ_q + OCC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_put) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (found ? hit_oh[i] : free_oh[i]) begin
					value_q[i] <= req.value;
				end
				if (!found && free_oh[i]) begin
					key_q[i] <= req.key;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
// top level of the lru key-value cache: request and response handshakes,
// capacity register; depends on lkvc_pkg and lkvc_store
//
//  channel | signals                      | direction | item
//  req     | req_valid, req_stall, req    | in        | command, key, value
//  rsp     | rsp_valid, rsp_stall, rsp    | out       | found, read_value
//  cfg     | cfg_valid, cfg_ready, cfg_data | in      | capacity limit
//
// one item per cycle sustained unless rsp stalls; a taken item is registered
// in req_s1 and its result, from the parallel key match over all entries, in rsp_s2
// reset clears all entries at once and sets the capacity limit to 16
// a stalled response holds the input register, which then stalls req
// cfg_ready is always high
module lru_key_value_cache #(
	parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  lkvc_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output lkvc_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data
);
	import lkvc_pkg::*;

	req_t             req_s1;
	logic             valid_s1;
	rsp_t             rsp_s2;
	logic             valid_s2;
	logic [CAP_W-1:0] cap_q;
	rsp_t             rsp_next;
	logic             advance;
	logic             take;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && valid_s2 && rsp_stall;
	assign take      = req_valid && !req_stall;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	lkvc_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.req   (req_s1),
		.cap   (cap_q),
		.rsp   (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cap_q    <= CAP_RESET;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

endmodule
